// ===== rtl/gtlsc_pkg.sv =====
// -----------------------------------------------------------------------------
// gtlsc_pkg
// Shared types and constants of the gimbal track / lost / search controller.
// -----------------------------------------------------------------------------
package gtlsc_pkg;

   // angle fields: signed 1/64 degree
   localparam int AngleW = 15;
   localparam int RangeW = 16;
   localparam int GainW  = 9;
   localparam int LostW  = 7;
   localparam int QuotW  = 17;

   localparam int CsrIdxW  = 3;
   localparam int CsrDataW = 15;

   // default frame counts
   localparam int LostLimitDef    = 5;
   localparam int SearchPeriodDef = 30;

   // register indexes
   localparam logic [CsrIdxW-1:0] REG_YAW_GAIN   = 3'd0;
   localparam logic [CsrIdxW-1:0] REG_PITCH_GAIN = 3'd1;
   localparam logic [CsrIdxW-1:0] REG_CMD_LIMIT  = 3'd2;
   localparam logic [CsrIdxW-1:0] REG_SWEEP_AMP  = 3'd3;
   localparam logic [CsrIdxW-1:0] REG_AIM_TOL    = 3'd4;
   localparam logic [CsrIdxW-1:0] REG_FIXED_EN   = 3'd5;
   localparam logic [CsrIdxW-1:0] REG_FIXED_YAW  = 3'd6;
   localparam logic [CsrIdxW-1:0] REG_FIXED_PITCH = 3'd7;

   // override flag codes
   localparam logic [1:0] FLAG_NONE  = 2'd0;
   localparam logic [1:0] FLAG_FIXED = 2'd2;

   // x/100 = (x * QuotMul) >> QuotShift, exact for x < 2^23
   localparam logic [23:0] QuotMul   = 24'd10737419;
   localparam int          QuotShift = 30;
   // x/5 = (x * DecayMul) >> DecayShift, exact for x < 2^17
   localparam logic [17:0] DecayMul   = 18'd209716;
   localparam int          DecayShift = 20;

   typedef struct packed {
      logic [GainW-1:0]         yaw_gain;
      logic [GainW-1:0]         pitch_gain;
      logic [5:0]               cmd_limit;
      logic [4:0]               sweep_amp;
      logic [13:0]              aim_tol;
      logic                     fixed_en;
      logic signed [AngleW-1:0] fixed_yaw;
      logic signed [AngleW-1:0] fixed_pitch;
   } cfg_type;

   typedef struct packed {
      logic                     pose_valid;
      logic signed [AngleW-1:0] yaw_ang;
      logic signed [AngleW-1:0] pitch_ang;
      logic [RangeW-1:0]        range_mm;
   } pose_type;

   // scaled pose: magnitudes of gain*error/100 and the sign of each command
   typedef struct packed {
      logic              pose_valid;
      logic              yaw_neg;
      logic              pitch_neg;
      logic              fire;
      logic [QuotW-1:0]  yaw_quot;
      logic [QuotW-1:0]  pitch_quot;
      logic [RangeW-1:0] range_mm;
   } scaled_type;

   typedef struct packed {
      logic [1:0]               track_mode;
      logic                     control_on;
      logic                     fire_ok;
      logic signed [AngleW-1:0] cmd_yaw;
      logic signed [AngleW-1:0] cmd_tilt;
      logic [RangeW-1:0]        cmd_range_mm;
      logic [1:0]               mode_flag;
   } result_type;

endpackage

// ===== rtl/gtlsc_csr.sv =====
// -----------------------------------------------------------------------------
// gtlsc_csr
// Configuration register file, one write per valid cycle.
// -----------------------------------------------------------------------------
module gtlsc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gtlsc_pkg::CsrIdxW-1:0]       csr_index,
   input  logic [gtlsc_pkg::CsrDataW-1:0]      csr_data,
   output gtlsc_pkg::cfg_type                  cfg
);

   gtlsc_pkg::cfg_type cfg_ff;
   gtlsc_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            gtlsc_pkg::REG_YAW_GAIN:    cfg_in.yaw_gain    = csr_data[8:0];
            gtlsc_pkg::REG_PITCH_GAIN:  cfg_in.pitch_gain  = csr_data[8:0];
            gtlsc_pkg::REG_CMD_LIMIT:   cfg_in.cmd_limit   = csr_data[5:0];
            gtlsc_pkg::REG_SWEEP_AMP:   cfg_in.sweep_amp   = csr_data[4:0];
            gtlsc_pkg::REG_AIM_TOL:     cfg_in.aim_tol     = csr_data[13:0];
            gtlsc_pkg::REG_FIXED_EN:    cfg_in.fixed_en    = csr_data[0];
            gtlsc_pkg::REG_FIXED_YAW:   cfg_in.fixed_yaw   = csr_data;
            gtlsc_pkg::REG_FIXED_PITCH: cfg_in.fixed_pitch = csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.yaw_gain    <= 9'd100;
         cfg_ff.pitch_gain  <= 9'd100;
         cfg_ff.cmd_limit   <= 6'd20;
         cfg_ff.sweep_amp   <= 5'd8;
         cfg_ff.aim_tol     <= 14'd64;
         cfg_ff.fixed_en    <= 1'b0;
         cfg_ff.fixed_yaw   <= 15'sd1920;
         cfg_ff.fixed_pitch <= 15'sd0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== rtl/gtlsc_scale.sv =====
// -----------------------------------------------------------------------------
// gtlsc_scale
// Pose scaling pipeline: input register, gain multiply, divide by 100.
// -----------------------------------------------------------------------------
module gtlsc_scale (
   input  logic                  clock,
   input  logic                  reset,
   input  gtlsc_pkg::cfg_type    cfg,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  gtlsc_pkg::pose_type   in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output gtlsc_pkg::scaled_type out_data
);

   typedef struct packed {
      logic                            pose_valid;
      logic                            yaw_neg;
      logic                            pitch_neg;
      logic                            fire;
      logic [23:0]                     yaw_prod;
      logic [23:0]                     pitch_prod;
      logic [gtlsc_pkg::RangeW-1:0]    range_mm;
   } prod_type;

   gtlsc_pkg::pose_type   s1_ff;
   prod_type              s2_ff, s2_in;
   gtlsc_pkg::scaled_type s3_ff, s3_in;
   logic                  v1_ff, v2_ff, v3_ff;
   logic                  en1, en2, en3;

   logic [gtlsc_pkg::AngleW-1:0] yaw_mag, pitch_mag;
   logic [47:0]                  yaw_full, pitch_full;

   // a stage loads when empty or when its contents move on
   assign en3      = !v3_ff || out_ready;
   assign en2      = !v2_ff || en3;
   assign en1      = !v1_ff || en2;
   assign in_ready = en1;

   assign yaw_mag   = s1_ff.yaw_ang[14]   ? 15'(-s1_ff.yaw_ang)   : s1_ff.yaw_ang;
   assign pitch_mag = s1_ff.pitch_ang[14] ? 15'(-s1_ff.pitch_ang) : s1_ff.pitch_ang;

   always_comb begin
      s2_in.pose_valid = s1_ff.pose_valid;
      // -yaw*gain is negative for positive yaw
      s2_in.yaw_neg    = !s1_ff.yaw_ang[14];
      s2_in.pitch_neg  = s1_ff.pitch_ang[14];
      s2_in.fire       = ({1'b0, yaw_mag} <= {2'b00, cfg.aim_tol}) &&
                         ({1'b0, pitch_mag} <= {2'b00, cfg.aim_tol});
      s2_in.yaw_prod   = 24'(yaw_mag) * 24'(cfg.yaw_gain);
      s2_in.pitch_prod = 24'(pitch_mag) * 24'(cfg.pitch_gain);
      s2_in.range_mm   = s1_ff.range_mm;
   end

   assign yaw_full   = 48'(s2_ff.yaw_prod) * 48'(gtlsc_pkg::QuotMul);
   assign pitch_full = 48'(s2_ff.pitch_prod) * 48'(gtlsc_pkg::QuotMul);

   always_comb begin
      s3_in.pose_valid = s2_ff.pose_valid;
      s3_in.yaw_neg    = s2_ff.yaw_neg;
      s3_in.pitch_neg  = s2_ff.pitch_neg;
      s3_in.fire       = s2_ff.fire;
      s3_in.yaw_quot   = yaw_full[gtlsc_pkg::QuotShift +: gtlsc_pkg::QuotW];
      s3_in.pitch_quot = pitch_full[gtlsc_pkg::QuotShift +: gtlsc_pkg::QuotW];
      s3_in.range_mm   = s2_ff.range_mm;
   end

   assign out_valid = v3_ff;
   assign out_data  = s3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) s1_ff <= in_data;
      if (en2) s2_ff <= s2_in;
      if (en3) s3_ff <= s3_in;
   end

endmodule

// ===== rtl/gtlsc_track.sv =====
// -----------------------------------------------------------------------------
// gtlsc_track
// Tracking state, held command, decay and sweep, and the result register.
// -----------------------------------------------------------------------------
module gtlsc_track #(
   parameter int LOST_LIMIT    = gtlsc_pkg::LostLimitDef,
   parameter int SEARCH_PERIOD = gtlsc_pkg::SearchPeriodDef
) (
   input  logic                  clock,
   input  logic                  reset,
   input  gtlsc_pkg::cfg_type    cfg,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  gtlsc_pkg::scaled_type in_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output gtlsc_pkg::result_type rsp_data
);

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_TRACK  = 2'd1,
      ST_LOST   = 2'd2,
      ST_SEARCH = 2'd3
   } state_type;

   // bit i: parity of i / period, built by counting
   function automatic logic [127:0] phase_mask(input int period);
      logic [127:0] m;
      int           cnt;
      logic         ph;
      m   = '0;
      cnt = 0;
      ph  = 1'b0;
      for (int i = 0; i < 128; i++) begin
         m[i] = ph;
         cnt  = cnt + 1;
         if (cnt == period) begin
            cnt = 0;
            ph  = ~ph;
         end
      end
      return m;
   endfunction

   localparam logic [gtlsc_pkg::LostW-1:0] LostLimitC = 7'(LOST_LIMIT);
   localparam logic [gtlsc_pkg::LostW-1:0] WrapLimitC = 7'(2 * SEARCH_PERIOD);
   localparam logic [gtlsc_pkg::LostW-1:0] RestartC   = 7'(LOST_LIMIT + 1);
   localparam logic [gtlsc_pkg::LostW-1:0] LostMaxC   =
      (RestartC > WrapLimitC) ? RestartC : WrapLimitC;
   localparam logic [127:0] PhaseMaskC = phase_mask(SEARCH_PERIOD);

   logic [gtlsc_pkg::LostW-1:0]         lost_ff, lost_in, lost_inc;
   logic signed [gtlsc_pkg::AngleW-1:0] held_yaw_ff, held_yaw_in;
   logic signed [gtlsc_pkg::AngleW-1:0] held_pitch_ff, held_pitch_in;
   logic [gtlsc_pkg::RangeW-1:0]        held_range_ff, held_range_in;
   logic                                held_control_ff, held_control_in;
   logic [1:0]                          held_flag_ff, held_flag_in;
   gtlsc_pkg::result_type               rsp_data_ff, rsp_data_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   state_type                           mode_in;
   logic                                take;

   logic [11:0]                         lim;
   logic [10:0]                         amp;
   logic [11:0]                         yaw_cmag, pitch_cmag;
   logic signed [gtlsc_pkg::AngleW-1:0] yaw_cmd, pitch_cmd;
   logic [gtlsc_pkg::AngleW-1:0]        held_yaw_mag, held_pitch_mag;
   logic [34:0]                         decay_yaw_prod, decay_pitch_prod;
   logic [gtlsc_pkg::AngleW-1:0]        decay_yaw_mag, decay_pitch_mag;
   logic signed [gtlsc_pkg::AngleW-1:0] decay_yaw, decay_pitch;

   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign take     = in_valid && in_ready;

   assign lost_inc = (lost_ff != 7'd127) ? lost_ff + 7'd1 : lost_ff;

   // zero limit or amplitude acts as one degree
   assign lim = {((cfg.cmd_limit == 6'd0) ? 6'd1 : cfg.cmd_limit), 6'b0};
   assign amp = {((cfg.sweep_amp == 5'd0) ? 5'd1 : cfg.sweep_amp), 6'b0};

   assign yaw_cmag   = (in_data.yaw_quot > 17'(lim))   ? lim : in_data.yaw_quot[11:0];
   assign pitch_cmag = (in_data.pitch_quot > 17'(lim)) ? lim : in_data.pitch_quot[11:0];
   assign yaw_cmd    = in_data.yaw_neg   ? 15'(15'd0 - 15'(yaw_cmag))   : 15'(yaw_cmag);
   assign pitch_cmd  = in_data.pitch_neg ? 15'(15'd0 - 15'(pitch_cmag)) : 15'(pitch_cmag);

   // held * 4 / 5, toward zero
   assign held_yaw_mag   = held_yaw_ff[14]   ? 15'(-held_yaw_ff)   : held_yaw_ff;
   assign held_pitch_mag = held_pitch_ff[14] ? 15'(-held_pitch_ff) : held_pitch_ff;
   assign decay_yaw_prod   = 35'({held_yaw_mag, 2'b00}) * 35'(gtlsc_pkg::DecayMul);
   assign decay_pitch_prod = 35'({held_pitch_mag, 2'b00}) * 35'(gtlsc_pkg::DecayMul);
   assign decay_yaw_mag   = decay_yaw_prod[gtlsc_pkg::DecayShift +: gtlsc_pkg::AngleW];
   assign decay_pitch_mag = decay_pitch_prod[gtlsc_pkg::DecayShift +: gtlsc_pkg::AngleW];
   assign decay_yaw   = held_yaw_ff[14]   ? 15'(15'd0 - decay_yaw_mag)   : decay_yaw_mag;
   assign decay_pitch = held_pitch_ff[14] ? 15'(15'd0 - decay_pitch_mag) : decay_pitch_mag;

   always_comb begin
      mode_in         = ST_IDLE;
      lost_in         = lost_ff;
      held_yaw_in     = held_yaw_ff;
      held_pitch_in   = held_pitch_ff;
      held_range_in   = held_range_ff;
      held_control_in = held_control_ff;
      held_flag_in    = held_flag_ff;
      rsp_data_in     = '0;

      if (cfg.fixed_en) begin
         mode_in                  = ST_TRACK;
         lost_in                  = '0;
         rsp_data_in.control_on   = 1'b1;
         rsp_data_in.cmd_yaw      = cfg.fixed_yaw;
         rsp_data_in.cmd_tilt     = cfg.fixed_pitch;
         rsp_data_in.mode_flag    = gtlsc_pkg::FLAG_FIXED;
         held_yaw_in              = cfg.fixed_yaw;
         held_pitch_in            = cfg.fixed_pitch;
         held_range_in            = '0;
         held_control_in          = 1'b1;
         held_flag_in             = gtlsc_pkg::FLAG_FIXED;
      end else if (in_data.pose_valid) begin
         mode_in                  = ST_TRACK;
         lost_in                  = '0;
         rsp_data_in.control_on   = 1'b1;
         rsp_data_in.fire_ok      = in_data.fire;
         rsp_data_in.cmd_yaw      = yaw_cmd;
         rsp_data_in.cmd_tilt     = pitch_cmd;
         rsp_data_in.cmd_range_mm = in_data.range_mm;
         rsp_data_in.mode_flag    = gtlsc_pkg::FLAG_NONE;
         held_yaw_in              = yaw_cmd;
         held_pitch_in            = pitch_cmd;
         held_range_in            = in_data.range_mm;
         held_control_in          = 1'b1;
         held_flag_in             = gtlsc_pkg::FLAG_NONE;
      end else if (lost_inc <= LostLimitC) begin
         mode_in                  = ST_LOST;
         lost_in                  = lost_inc;
         held_yaw_in              = decay_yaw;
         held_pitch_in            = decay_pitch;
         rsp_data_in.control_on   = held_control_ff;
         rsp_data_in.cmd_yaw      = decay_yaw;
         rsp_data_in.cmd_tilt     = decay_pitch;
         rsp_data_in.cmd_range_mm = held_range_ff;
         rsp_data_in.mode_flag    = held_flag_ff;
      end else begin
         mode_in                  = ST_SEARCH;
         lost_in                  = (lost_inc > WrapLimitC) ? RestartC : lost_inc;
         rsp_data_in.control_on   = 1'b1;
         rsp_data_in.cmd_yaw      = PhaseMaskC[lost_inc] ? 15'(15'd0 - 15'(amp)) : 15'(amp);
         rsp_data_in.mode_flag    = gtlsc_pkg::FLAG_NONE;
      end
      rsp_data_in.track_mode = mode_in;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take)           rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff    <= 1'b0;
         lost_ff         <= '0;
         held_yaw_ff     <= '0;
         held_pitch_ff   <= '0;
         held_range_ff   <= '0;
         held_control_ff <= 1'b0;
         held_flag_ff    <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            lost_ff         <= lost_in;
            held_yaw_ff     <= held_yaw_in;
            held_pitch_ff   <= held_pitch_in;
            held_range_ff   <= held_range_in;
            held_control_ff <= held_control_in;
            held_flag_ff    <= held_flag_in;
         end
      end
      if (take) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // lost counter stays within the wrap window
   a_lost_bound: assert property (@(posedge clock) disable iff (reset)
      lost_ff <= LostMaxC)
      else $error("lost counter out of range");

   // a search command carries no pitch and no range
   a_search_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.track_mode == 2'(ST_SEARCH)) |->
         (rsp_data_ff.cmd_tilt == '0) && (rsp_data_ff.cmd_range_mm == '0) &&
         rsp_data_ff.control_on && !rsp_data_ff.fire_ok)
      else $error("search command malformed");

   // decay never grows the held yaw
   a_decay_shrinks: assert property (@(posedge clock) disable iff (reset)
      take && (mode_in == ST_LOST) |=> held_yaw_mag <= $past(held_yaw_mag))
      else $error("held yaw grew while lost");

   // tracked command from a pose respects the clamp
   a_clamp: assert property (@(posedge clock) disable iff (reset)
      take && !cfg.fixed_en && in_data.pose_valid |->
         (yaw_cmag <= lim) && (pitch_cmag <= lim))
      else $error("tracking command exceeds limit");

   // fixed mode never fires
   a_fixed_no_fire: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_data_ff.mode_flag == gtlsc_pkg::FLAG_FIXED) |->
         !rsp_data_ff.fire_ok)
      else $error("fire raised in fixed mode");

endmodule

// ===== rtl/gimbal_track_lost_search_control.sv =====
// -----------------------------------------------------------------------------
// gimbal_track_lost_search_control
// Per-frame gimbal command from a pose result, with lost decay and search.
// -----------------------------------------------------------------------------
// One request per camera frame enters on the req_ stream (pose in tdata, the
// pose-solved flag in tuser); one command leaves on the rsp_ stream for each
// request, in order. Gains, limits, tolerance and the fixed test target are
// written on the csr_ channel, which is always ready; write it only while no
// request is in flight.
// Path: input register, gain multiply, reciprocal divide by 100, then the
// result register, which drives rsp_tvalid. Throughput: one request per
// cycle while rsp_tready does not stall; the input register, the two
// multiplier stages and the result register each hold one request, and the
// track state (held command, lost counter) updates as a request enters the
// result register. Reset clears the pipeline and the tracking state (lost
// counter and held command zero) and loads the register defaults. When
// rsp_tready is low the result is held and the pipeline keeps filling its
// empty stages; req_tready drops only when every stage holds a request.
// -----------------------------------------------------------------------------
module gimbal_track_lost_search_control #(
   parameter int LOST_LIMIT    = gtlsc_pkg::LostLimitDef,
   parameter int SEARCH_PERIOD = gtlsc_pkg::SearchPeriodDef
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // [14:0] yaw_ang, [29:15] pitch_ang, [45:30] range_mm, [47:46] zero
   input  logic [47:0]                      req_tdata,
   // [0] pose_valid
   input  logic                             req_tuser,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // [0] control_on, [1] fire_ok, [16:2] cmd_yaw, [31:17] cmd_tilt,
   // [47:32] cmd_range_mm
   output logic [47:0]                      rsp_tdata,
   // [1:0] track_mode, [3:2] mode_flag
   output logic [3:0]                       rsp_tuser,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [gtlsc_pkg::CsrIdxW-1:0]    csr_index,
   input  logic [gtlsc_pkg::CsrDataW-1:0]   csr_data
);

   gtlsc_pkg::cfg_type    cfg;
   gtlsc_pkg::pose_type   pose;
   gtlsc_pkg::scaled_type scaled;
   gtlsc_pkg::result_type result;
   logic                  scaled_valid, scaled_ready;

   assign pose.pose_valid = req_tuser;
   assign pose.yaw_ang    = req_tdata[14:0];
   assign pose.pitch_ang  = req_tdata[29:15];
   assign pose.range_mm   = req_tdata[45:30];

   gtlsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   gtlsc_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (pose),
      .out_valid (scaled_valid),
      .out_ready (scaled_ready),
      .out_data  (scaled)
   );

   gtlsc_track #(
      .LOST_LIMIT    (LOST_LIMIT),
      .SEARCH_PERIOD (SEARCH_PERIOD)
   ) u_track (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (scaled_valid),
      .in_ready  (scaled_ready),
      .in_data   (scaled),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (result)
   );

   assign rsp_tdata = {result.cmd_range_mm, result.cmd_tilt, result.cmd_yaw,
                       result.fire_ok, result.control_on};
   assign rsp_tuser = {result.mode_flag, result.track_mode};

endmodule
